### rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg: shared types and codes of the quaternion arithmetic unit
// Operation codes, the control word handed to the result stage and the
// status flags that travel with every result item.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

  localparam int unsigned OP_W  = 4;
  localparam int unsigned ROW_W = 2;

  // Index of the final matrix row.
  localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_MULVEC = 4'd3,
    OP_SCALE  = 4'd4,
    OP_NEGATE = 4'd5,
    OP_CONJ   = 4'd6,
    OP_DOT    = 4'd7,
    OP_EQUAL  = 4'd8,
    OP_MATRIX = 4'd9
  } qau_op_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
  } qau_ctl_t;

  typedef struct packed {
    logic equal_flag;
    logic overflow;
    logic last_result;
  } qau_flags_t;

endpackage

`default_nettype wire

### rtl/qau_in_if.sv
// ----------------------------------------------------------------------------
// qau_in_if: request channel of the quaternion arithmetic unit
// Valid/ready handshake carrying the opcode, two quaternions and a scalar.
// ----------------------------------------------------------------------------
`default_nettype none

interface qau_in_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic [qau_pkg::OP_W-1:0]     operation;
  logic signed [DATA_WIDTH-1:0] a_w;
  logic signed [DATA_WIDTH-1:0] a_x;
  logic signed [DATA_WIDTH-1:0] a_y;
  logic signed [DATA_WIDTH-1:0] a_z;
  logic signed [DATA_WIDTH-1:0] b_w;
  logic signed [DATA_WIDTH-1:0] b_x;
  logic signed [DATA_WIDTH-1:0] b_y;
  logic signed [DATA_WIDTH-1:0] b_z;
  logic signed [DATA_WIDTH-1:0] scale_factor;

  modport source (
    output valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor,
    input  ready
  );

  modport sink (
    input  valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor,
    output ready
  );
endinterface

`default_nettype wire

### rtl/qau_out_if.sv
// ----------------------------------------------------------------------------
// qau_out_if: result channel of the quaternion arithmetic unit
// Valid/ready handshake carrying one quaternion or matrix row and its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface qau_out_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_w;
  logic signed [DATA_WIDTH-1:0] out_x;
  logic signed [DATA_WIDTH-1:0] out_y;
  logic signed [DATA_WIDTH-1:0] out_z;
  logic                         equal_flag;
  logic                         overflow;
  logic                         last_result;

  modport source (
    output valid, out_w, out_x, out_y, out_z, equal_flag, overflow, last_result,
    input  ready
  );

  modport sink (
    input  valid, out_w, out_x, out_y, out_z, equal_flag, overflow, last_result,
    output ready
  );
endinterface

`default_nettype wire

### rtl/qau_prod.sv
// ----------------------------------------------------------------------------
// qau_prod: operand selection and product register
// Sixteen parallel multipliers fed by opcode-dependent operands; the
// products and the raw operands are registered for the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_prod #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           load_i,
  input  wire logic [qau_pkg::OP_W-1:0]       op_i,
  input  wire logic signed [DATA_WIDTH-1:0]   a_i [4],
  input  wire logic signed [DATA_WIDTH-1:0]   b_i [4],
  input  wire logic signed [DATA_WIDTH-1:0]   scale_i,
  output logic      [qau_pkg::OP_W-1:0]       op_o,
  output logic signed [DATA_WIDTH-1:0]        a_o [4],
  output logic signed [DATA_WIDTH-1:0]        b_o [4],
  output logic signed [2*DATA_WIDTH-1:0]      p_o [16]
);
  import qau_pkg::*;

  localparam int unsigned PW = 2 * DATA_WIDTH;

  // Component indices (w, x, y, z) of each multiplier lane, laid out so that
  // the lanes form the Hamilton product terms in groups of four.
  localparam int unsigned A_IDX [16] = '{0, 1, 2, 3, 1, 0, 2, 3, 2, 0, 3, 1, 3, 0, 1, 2};
  localparam int unsigned B_IDX [16] = '{0, 1, 2, 3, 0, 1, 3, 2, 0, 2, 1, 3, 0, 3, 2, 1};

  logic signed [DATA_WIDTH-1:0] bsel [4];
  logic signed [DATA_WIDTH-1:0] opa  [16];
  logic signed [DATA_WIDTH-1:0] opb  [16];
  logic signed [PW-1:0]         p_d  [16];
  logic [OP_W-1:0]              op_q;
  logic signed [DATA_WIDTH-1:0] a_q  [4];
  logic signed [DATA_WIDTH-1:0] b_q  [4];
  logic signed [PW-1:0]         p_q  [16];

  // The vector product drops the scalar of b; the matrix squares the
  // vector of a onto itself, so its b vector is replaced by a's.
  always_comb begin
    bsel = b_i;
    if (op_i == OP_MULVEC) begin
      bsel[0] = '0;
    end else if (op_i == OP_MATRIX) begin
      bsel[1] = a_i[1];
      bsel[2] = a_i[2];
      bsel[3] = a_i[3];
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      opa[i] = a_i[A_IDX[i]];
      opb[i] = bsel[B_IDX[i]];
      if (op_i == OP_SCALE && i < 4) begin
        opb[i] = scale_i;
      end
      p_d[i] = PW'(opa[i]) * PW'(opb[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q <= op_i;
      a_q  <= a_i;
      b_q  <= b_i;
      p_q  <= p_d;
    end
  end

  assign op_o = op_q;
  assign a_o  = a_q;
  assign b_o  = b_q;
  assign p_o  = p_q;

endmodule

`default_nettype wire

### rtl/qau_form.sv
// ----------------------------------------------------------------------------
// qau_form: result forming
// Sums the registered products or operands per lane, rounds product sums,
// saturates every component and builds the result flags.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_form #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  wire qau_pkg::qau_ctl_t                ctl_i,
  input  wire logic signed [DATA_WIDTH-1:0]     a_i [4],
  input  wire logic signed [DATA_WIDTH-1:0]     b_i [4],
  input  wire logic signed [2*DATA_WIDTH-1:0]   p_i [16],
  output logic signed [DATA_WIDTH-1:0]          res_o [4],
  output qau_pkg::qau_flags_t                   flags_o
);
  import qau_pkg::*;

  localparam int unsigned W      = DATA_WIDTH;
  localparam int unsigned ACC_A  = 2 * W + 3;
  localparam int unsigned ACC_B  = 2 * FRAC_BITS + 2;
  localparam int unsigned ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ONE    = ACC_W'(1) << (2 * FRAC_BITS);

  // Saturate to W bits; the top bit of the result marks a clipped value.
  function automatic logic [W:0] sat_fn(input logic signed [ACC_W-1:0] v);
    logic [W:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[W-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic signed [ACC_W-1:0] pe  [16];
  logic signed [ACC_W-1:0] ae  [4];
  logic signed [ACC_W-1:0] be  [4];
  logic signed [ACC_W-1:0] s   [4];
  logic signed [ACC_W-1:0] v   [4];
  logic [W:0]              r   [4];
  logic                    rnd_en;
  logic                    eq;
  logic                    ovf;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pe[i] = ACC_W'(p_i[i]);
    end
    for (int i = 0; i < 4; i++) begin
      ae[i] = ACC_W'(a_i[i]);
      be[i] = ACC_W'(b_i[i]);
    end
  end

  always_comb begin
    s      = '{default: '0};
    rnd_en = 1'b0;
    eq     = 1'b0;
    unique case (ctl_i.op) inside
      OP_ADD: begin
        for (int i = 0; i < 4; i++) s[i] = ae[i] + be[i];
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) s[i] = ae[i] - be[i];
      end
      OP_MUL, OP_MULVEC: begin
        rnd_en = 1'b1;
        s[0] = pe[0] - pe[1] - pe[2] - pe[3];
        s[1] = pe[4] + pe[5] + pe[6] - pe[7];
        s[2] = pe[8] + pe[9] + pe[10] - pe[11];
        s[3] = pe[12] + pe[13] + pe[14] - pe[15];
      end
      OP_SCALE: begin
        rnd_en = 1'b1;
        for (int i = 0; i < 4; i++) s[i] = pe[i];
      end
      OP_NEGATE: begin
        for (int i = 0; i < 4; i++) s[i] = -ae[i];
      end
      OP_CONJ: begin
        s[0] = ae[0];
        for (int i = 1; i < 4; i++) s[i] = -ae[i];
      end
      OP_DOT: begin
        rnd_en = 1'b1;
        s[0] = pe[0] + pe[1] + pe[2] + pe[3];
      end
      OP_EQUAL: begin
        eq = (a_i[0] == b_i[0]) && (a_i[1] == b_i[1]) &&
             (a_i[2] == b_i[2]) && (a_i[3] == b_i[3]);
      end
      OP_MATRIX: begin
        // Lanes hold xx, yy, zz, xy, xz, yz, wx, wy and wz; each is doubled.
        rnd_en = 1'b1;
        unique case (ctl_i.row)
          2'd0: begin
            s[1] = ONE - ((pe[2] + pe[3]) <<< 1);
            s[2] = (pe[14] - pe[13]) <<< 1;
            s[3] = (pe[11] + pe[9]) <<< 1;
          end
          2'd1: begin
            s[1] = (pe[14] + pe[13]) <<< 1;
            s[2] = ONE - ((pe[1] + pe[3]) <<< 1);
            s[3] = (pe[6] - pe[5]) <<< 1;
          end
          ROW_LAST: begin
            s[1] = (pe[11] - pe[9]) <<< 1;
            s[2] = (pe[6] + pe[5]) <<< 1;
            s[3] = ONE - ((pe[1] + pe[2]) <<< 1);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      v[i]     = rnd_en ? ((s[i] + HALF) >>> FRAC_BITS) : s[i];
      r[i]     = sat_fn(v[i]);
      res_o[i] = r[i][W-1:0];
      ovf      = ovf | r[i][W];
    end
  end

  always_comb begin
    flags_o.equal_flag  = eq;
    flags_o.overflow    = ovf;
    flags_o.last_result = (ctl_i.op == OP_MATRIX) ? (ctl_i.row == ROW_LAST) : 1'b1;
  end

endmodule

`default_nettype wire

### rtl/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit: fixed-point quaternion ALU
// Add, subtract, Hamilton and vector products, scale, negate, conjugate,
// dot product, equality and rotation matrix rows, rounded and saturated.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+---------------------------------
//   req_i    | in        | valid / ready | operation, a_*, b_*, scale_factor
//   rsp_o    | out       | valid / ready | out_*, equal_flag, overflow,
//            |           |               | last_result
//
// One single-result item per cycle while rsp_o is not stalled; a matrix item occupies
// the product register until its three rows are emitted, one row per result. A result
// passes through the product register and then the result register before it can be taken.
// Throughput is set by the product register, which holds an item until all
// of its results have moved into the result register.
// Reset clears the valid flags and the row counter only. A stalled result
// holds the result register and, once the product register is full, req_i.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qau_in_if.sink    req_i,
  qau_out_if.source rsp_o
);
  import qau_pkg::*;

  logic signed [DATA_WIDTH-1:0]   a_in  [4];
  logic signed [DATA_WIDTH-1:0]   b_in  [4];
  logic [OP_W-1:0]                op_s1;
  logic signed [DATA_WIDTH-1:0]   a_s1  [4];
  logic signed [DATA_WIDTH-1:0]   b_s1  [4];
  logic signed [2*DATA_WIDTH-1:0] p_s1  [16];
  logic signed [DATA_WIDTH-1:0]   res   [4];
  qau_flags_t                     flags;
  qau_ctl_t                       ctl;

  logic                           s1_valid_q, s1_valid_d;
  logic [ROW_W-1:0]               row_q, row_d;
  logic                           out_valid_q, out_valid_d;
  logic signed [DATA_WIDTH-1:0]   res_q [4];
  qau_flags_t                     flags_q;

  logic                           accept;
  logic                           is_mat;
  logic                           out_free;
  logic                           s1_fire;
  logic                           s1_leave;

  assign a_in = '{req_i.a_w, req_i.a_x, req_i.a_y, req_i.a_z};
  assign b_in = '{req_i.b_w, req_i.b_x, req_i.b_y, req_i.b_z};

  qau_prod #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prod (
    .clk_i   (clk_i),
    .load_i  (accept),
    .op_i    (req_i.operation),
    .a_i     (a_in),
    .b_i     (b_in),
    .scale_i (req_i.scale_factor),
    .op_o    (op_s1),
    .a_o     (a_s1),
    .b_o     (b_s1),
    .p_o     (p_s1)
  );

  assign ctl.op  = op_s1;
  assign ctl.row = row_q;

  qau_form #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_form (
    .ctl_i   (ctl),
    .a_i     (a_s1),
    .b_i     (b_s1),
    .p_i     (p_s1),
    .res_o   (res),
    .flags_o (flags)
  );

  // A result moves on whenever the result register is empty or being taken;
  // the product register frees up only after the final result of its item.
  assign is_mat   = (op_s1 == OP_MATRIX);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign s1_leave = s1_fire && (!is_mat || (row_q == ROW_LAST));
  assign req_i.ready = !s1_valid_q || s1_leave;
  assign accept   = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d  = accept || (s1_valid_q && !s1_leave);
    out_valid_d = s1_fire || (out_valid_q && !rsp_o.ready);
    row_d       = row_q;
    if (s1_leave) begin
      row_d = '0;
    end else if (s1_fire) begin
      row_d = row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q   <= res;
      flags_q <= flags;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_w       = res_q[0];
  assign rsp_o.out_x       = res_q[1];
  assign rsp_o.out_y       = res_q[2];
  assign rsp_o.out_z       = res_q[3];
  assign rsp_o.equal_flag  = flags_q.equal_flag;
  assign rsp_o.overflow    = flags_q.overflow;
  assign rsp_o.last_result = flags_q.last_result;

`ifndef SYNTHESIS
  a_mat_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && is_mat && (row_q != ROW_LAST) |-> !req_i.ready)
    else $error("request taken while matrix rows are still pending");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_LAST)
    else $error("matrix row counter out of range");

  a_row_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.last_result |-> s1_valid_q && is_mat)
    else $error("non-final row shown without its item in the product register");

  a_row_only_on_mat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !is_mat |-> row_q == '0)
    else $error("row counter advanced on a single-result item");
`endif

endmodule

`default_nettype wire
